[rtl/core/i2cbs_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
`default_nettype none
package i2cbs_pkg;

  typedef enum logic [2:0] {
    REQ_INIT    = 3'd0,
    REQ_START   = 3'd1,
    REQ_RESTART = 3'd2,
    REQ_STOP    = 3'd3,
    REQ_ACK     = 3'd4,
    REQ_NACK    = 3'd5,
    REQ_WRITE   = 3'd6,
    REQ_READ    = 3'd7
  } req_t;

  localparam int unsigned PHASE_W  = 5;
  localparam int unsigned HOLD_W   = 10;
  localparam int unsigned DELAY_W  = 8;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd5;
  localparam logic [2:0]         LAST_BIT    = 3'd7;
  localparam logic [1:0]         LAST_SUB    = 2'd2;
  localparam logic [PHASE_W-1:0] WR_ACK_LOW  = 5'd24;
  localparam logic [PHASE_W-1:0] WR_ACK_HIGH = 5'd25;
  localparam logic [PHASE_W-1:0] MAX_PHASE   = 5'd25;

  // One line phase as it leaves the generator
  typedef struct packed {
    logic              scl;
    logic              sda;
    logic [HOLD_W-1:0] hold;
    logic              smp;
    logic [BYTE_W-1:0] rx;
    logic              ack;
    logic              last;
  } phase_t;

endpackage
`default_nettype wire

[rtl/core/i2cbs_phase_gen.sv]
// Combinational decode of one line phase from command and phase position.
`default_nettype none
module i2cbs_phase_gen (
  input  wire i2cbs_pkg::req_t                  req,
  input  wire logic [i2cbs_pkg::PHASE_W-1:0]    phase,
  input  wire logic [1:0]                       sub,
  input  wire logic [2:0]                       bit_idx,
  input  wire logic [i2cbs_pkg::BYTE_W-1:0]     tx_byte,
  input  wire logic [i2cbs_pkg::BYTE_W-1:0]     slave_bits,
  input  wire logic                             sda_now,
  input  wire logic [i2cbs_pkg::DELAY_W-1:0]    delay_unit,
  output i2cbs_pkg::phase_t                     ph
);

  logic [i2cbs_pkg::HOLD_W-1:0] hold_x1;
  logic [i2cbs_pkg::HOLD_W-1:0] hold_x2;
  logic [i2cbs_pkg::HOLD_W-1:0] hold_x4;
  logic                         tx_bit;

  assign hold_x1 = {2'b00, delay_unit};
  assign hold_x2 = {1'b0, delay_unit, 1'b0};
  assign hold_x4 = {delay_unit, 2'b00};
  assign tx_bit  = tx_byte[i2cbs_pkg::LAST_BIT - bit_idx];

  always_comb begin
    ph      = '0;
    ph.scl  = 1'b1;
    ph.sda  = 1'b1;
    ph.hold = hold_x1;
    case (req)
      i2cbs_pkg::REQ_INIT: begin
        ph.hold = '0;
        ph.last = 1'b1;
      end
      i2cbs_pkg::REQ_START: begin
        ph.sda  = (phase[0] == 1'b0);
        ph.last = phase[0];
      end
      i2cbs_pkg::REQ_RESTART: begin
        case (phase[1:0])
          2'd0: begin ph.scl = 1'b0; ph.sda = sda_now; end
          2'd1: begin ph.scl = 1'b0; end
          2'd2: begin end
          default: begin ph.sda = 1'b0; ph.last = 1'b1; end
        endcase
      end
      i2cbs_pkg::REQ_STOP: begin
        case (phase[1:0])
          2'd0: begin ph.scl = 1'b0; ph.sda = sda_now; end
          2'd1: begin ph.scl = 1'b0; ph.sda = 1'b0; end
          2'd2: begin ph.sda = 1'b0; end
          default: begin ph.last = 1'b1; end
        endcase
      end
      i2cbs_pkg::REQ_ACK, i2cbs_pkg::REQ_NACK: begin
        // ack drives low, nack leaves the line released
        case (phase[1:0])
          2'd0: begin ph.scl = 1'b0; ph.sda = sda_now; ph.hold = hold_x2; end
          2'd1: begin
            ph.scl  = 1'b0;
            ph.sda  = (req == i2cbs_pkg::REQ_NACK);
            ph.hold = hold_x2;
          end
          default: begin
            ph.sda  = (req == i2cbs_pkg::REQ_NACK);
            ph.hold = hold_x4;
            ph.last = 1'b1;
          end
        endcase
      end
      i2cbs_pkg::REQ_WRITE: begin
        if (phase == i2cbs_pkg::WR_ACK_LOW) begin
          ph.scl = 1'b0;
        end else if (phase == i2cbs_pkg::WR_ACK_HIGH) begin
          ph.smp  = 1'b1;
          ph.ack  = slave_bits[0];
          ph.last = 1'b1;
        end else begin
          case (sub)
            2'd0:    begin ph.scl = 1'b0; ph.sda = sda_now; end
            2'd1:    begin ph.scl = 1'b0; ph.sda = tx_bit; end
            default: begin ph.sda = tx_bit; end
          endcase
        end
      end
      i2cbs_pkg::REQ_READ: begin
        case (sub)
          2'd0: begin ph.scl = 1'b0; end
          2'd1: begin ph.smp = 1'b1; end
          default: begin
            if (bit_idx == i2cbs_pkg::LAST_BIT) begin
              ph.rx   = slave_bits;
              ph.last = 1'b1;
            end
          end
        endcase
      end
      default: begin
        ph.last = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/i2c_master_bit_sequencer.sv]
// Top level of the I2C master bit sequencer: command register, phase walk, result register.
// Usage:
//   Input channel (in_valid/in_ready) takes one command beat: in_req_type selects
//   init, start, restart, stop, ack, nack, write byte or read byte; in_tx_byte is the
//   byte to send and in_slave_bits the levels the slave drives.
//   Output channel (out_valid/out_ready) gives one beat per line phase: SCL/SDA levels,
//   hold time in delay units, sample mark, received byte, ack level and last mark.
//   cfg_we/cfg_wdata write the delay unit; write only while the block is idle.
// Throughput: one phase beat per cycle while out_ready is high. A command gives one beat
//   per phase (init 1, start 2, restart/stop 4, ack/nack 3, read 24, write 26); the
//   phase counter walks the command register through those phases. The next command is
//   taken in the cycle its predecessor's last phase moves to the result register.
// Path: a beat enters the command register; its phases leave via the result register.
// Stall: when out_ready is low the result register holds its beat and the phase walk
//   pauses; one command waits in the command register meanwhile.
// Reset: clears both channels, sets the delay unit to 5 and the SDA level to released.
`default_nettype none
module i2c_master_bit_sequencer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_req_type,
  input  wire logic [7:0] in_tx_byte,
  input  wire logic [7:0] in_slave_bits,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_scl_level,
  output logic            out_sda_level,
  output logic [9:0]      out_hold_units,
  output logic            out_sample_point,
  output logic [7:0]      out_rx_byte,
  output logic            out_ack_seen,
  output logic            out_last_phase
);

  logic [i2cbs_pkg::DELAY_W-1:0] delay_unit_r;
  logic                          sda_now_r;

  logic                          cmd_valid_r;
  i2cbs_pkg::req_t               cmd_req_r;
  logic [i2cbs_pkg::BYTE_W-1:0]  cmd_tx_r;
  logic [i2cbs_pkg::BYTE_W-1:0]  cmd_sb_r;
  logic [i2cbs_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [1:0]                    sub_r, sub_nxt;
  logic [2:0]                    bit_r, bit_nxt;

  logic                          out_valid_r;
  i2cbs_pkg::phase_t             out_r;

  i2cbs_pkg::phase_t             ph;
  logic                          gen_fire;
  logic                          in_fire;

  i2cbs_phase_gen u_phase_gen (
    .req        (cmd_req_r),
    .phase      (phase_r),
    .sub        (sub_r),
    .bit_idx    (bit_r),
    .tx_byte    (cmd_tx_r),
    .slave_bits (cmd_sb_r),
    .sda_now    (sda_now_r),
    .delay_unit (delay_unit_r),
    .ph         (ph)
  );

  assign gen_fire = cmd_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !cmd_valid_r || (gen_fire && ph.last);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r + 5'd1;
    sub_nxt   = sub_r + 2'd1;
    bit_nxt   = bit_r;
    if (sub_r == i2cbs_pkg::LAST_SUB) begin
      sub_nxt = 2'd0;
      bit_nxt = bit_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_unit_r <= i2cbs_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      delay_unit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      phase_r     <= '0;
      sub_r       <= '0;
      bit_r       <= '0;
    end else if (in_fire) begin
      cmd_valid_r <= 1'b1;
      phase_r     <= '0;
      sub_r       <= '0;
      bit_r       <= '0;
    end else if (gen_fire) begin
      if (ph.last) begin
        cmd_valid_r <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        sub_r   <= sub_nxt;
        bit_r   <= bit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_req_r <= i2cbs_pkg::req_t'(in_req_type);
      cmd_tx_r  <= in_tx_byte;
      cmd_sb_r  <= in_slave_bits;
    end
  end

  // line state follows generation order, which is also beat order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sda_now_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else if (gen_fire) begin
      sda_now_r   <= ph.sda;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_fire) begin
      out_r <= ph;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_level    = out_r.scl;
  assign out_sda_level    = out_r.sda;
  assign out_hold_units   = out_r.hold;
  assign out_sample_point = out_r.smp;
  assign out_rx_byte      = out_r.rx;
  assign out_ack_seen     = out_r.ack;
  assign out_last_phase   = out_r.last;

`ifndef ASSERT_OFF
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid_r |-> (phase_r <= i2cbs_pkg::MAX_PHASE))
    else $error("phase counter past the longest command");

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid_r |-> (sub_r != 2'd3))
    else $error("bit sub-phase out of range");

  a_cmd_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_fire && !ph.last) |=> cmd_valid_r)
    else $error("command dropped before its last phase");

  a_sample_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sample_point) |-> out_scl_level)
    else $error("sample point outside an SCL high phase");

  a_no_gen_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_r))
    else $error("result register changed while stalled");
`endif

endmodule
`default_nettype wire
